FILE: hdl/pemp_pkg.sv
// ----------------------------------------------------------------------------
// pemp_pkg: shared types and constants of the pointer event converter
// Event codes, packet constants, and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package pemp_pkg;

	// Field and register widths
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam int VAL_W  = 32;
	localparam int DIFF_W = VAL_W + 1;
	localparam int SCR_W  = 15;
	localparam int PROD_W = DIFF_W + SCR_W;

	// Register indexes of the configuration port
	localparam logic [CFG_AW-1:0] CFG_X_MIN  = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_X_MAX  = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_Y_MIN  = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_Y_MAX  = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_SCR_X  = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_SCR_Y  = 3'd5;

	localparam logic [SCR_W-1:0] SCR_X_RESET = 15'd639;
	localparam logic [SCR_W-1:0] SCR_Y_RESET = 15'd399;

	// Event classes and codes
	localparam logic [15:0] EV_TYPE_KEY = 16'd1;
	localparam logic [15:0] EV_TYPE_REL = 16'd2;
	localparam logic [15:0] EV_TYPE_ABS = 16'd3;
	localparam logic [15:0] EV_AXIS_X   = 16'd0;
	localparam logic [15:0] EV_AXIS_Y   = 16'd1;
	localparam logic [15:0] EV_BTN_LEFT = 16'h110;
	localparam logic [15:0] EV_BTN_RGHT = 16'h111;
	localparam logic [15:0] EV_BTN_MID  = 16'h112;

	// Packet constants
	localparam logic        KIND_PACKET   = 1'b0;
	localparam logic        KIND_EXTRA    = 1'b1;
	localparam logic [7:0]  HDR_BASE      = 8'hF8;
	localparam logic [1:0]  BIT_LEFT      = 2'b10;
	localparam logic [1:0]  BIT_RIGHT     = 2'b01;
	localparam logic [7:0]  EXTRA_PRESS   = 8'h37;
	localparam logic [7:0]  EXTRA_RELEASE = 8'hB7;
	localparam logic signed [7:0] STEP_HI = 8'sh7F;
	localparam logic signed [7:0] STEP_LO = 8'sh80;

	// Event classification
	typedef enum logic [2:0] {
		EVK_NONE,
		EVK_BUTTON,
		EVK_MIDDLE,
		EVK_REL,
		EVK_ABS
	} evk_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SCALE,
		ST_STORE,
		ST_STEP,
		ST_EXTRA
	} st_t;

	// Controller to datapath
	typedef struct packed {
		logic load_event;
		logic prep;
		logic button_update;
		logic load_zero;
		logic load_rel;
		logic mul;
		logic div_start;
		logic scale;
		logic store;
		logic load_delta;
		logic emit_step;
		logic emit_extra;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		evk_t kind;
		logic range_empty;
		logic axis_seen;
		logic out_free;
		logic div_done;
		logic step_last;
	} sts_t;

endpackage

FILE: hdl/pemp_event_if.sv
// ----------------------------------------------------------------------------
// pemp_event_if: input event channel
// One beat carries one pointer event: type, code and value.
// ----------------------------------------------------------------------------
interface pemp_event_if;
	logic               valid;
	logic               ready;
	logic [15:0]        event_type;
	logic [15:0]        event_code;
	logic signed [31:0] event_value;

	modport source (output valid, output event_type, output event_code,
		output event_value, input ready);
	modport sink (input valid, input event_type, input event_code,
		input event_value, output ready);
endinterface

FILE: hdl/pemp_result_if.sv
// ----------------------------------------------------------------------------
// pemp_result_if: result channel
// One beat carries one mouse packet or one extra middle-button byte.
// ----------------------------------------------------------------------------
interface pemp_result_if;
	logic              valid;
	logic              ready;
	logic              result_kind;
	logic [7:0]        packet_header;
	logic signed [7:0] step_dx;
	logic signed [7:0] step_dy;
	logic [7:0]        extra_button_byte;
	logic              last_of_run;

	modport source (output valid, output result_kind, output packet_header,
		output step_dx, output step_dy, output extra_button_byte,
		output last_of_run, input ready);
	modport sink (input valid, input result_kind, input packet_header,
		input step_dx, input step_dy, input extra_button_byte,
		input last_of_run, output ready);
endinterface

FILE: hdl/pemp_div.sv
// ----------------------------------------------------------------------------
// pemp_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pemp_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quot,
	output logic             done
);

	localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// Shift the next dividend bit into the partial remainder and compare
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Advance remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign quot = num_q;
	assign done = done_q;

endmodule

FILE: hdl/pemp_ctrl.sv
// ----------------------------------------------------------------------------
// pemp_ctrl: controller of the pointer event converter
// Walks each event through decode, scaling of absolute events, and packet emission.
// ----------------------------------------------------------------------------
module pemp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ev_valid,
	output logic           ev_ready,
	input  pemp_pkg::sts_t sts,
	output pemp_pkg::cmd_t cmd
);

	pemp_pkg::st_t state_q;
	pemp_pkg::st_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pemp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		ev_ready  = 1'b0;
		case (state_q)
			pemp_pkg::ST_IDLE: begin
				ev_ready = 1'b1;
				if (ev_valid) begin
					cmd.load_event = 1'b1;
					state_nxt      = pemp_pkg::ST_DECODE;
				end
			end
			pemp_pkg::ST_DECODE: begin
				cmd.prep = 1'b1;
				case (sts.kind)
					pemp_pkg::EVK_BUTTON: begin
						cmd.button_update = 1'b1;
						cmd.load_zero     = 1'b1;
						state_nxt         = pemp_pkg::ST_STEP;
					end
					pemp_pkg::EVK_MIDDLE: state_nxt = pemp_pkg::ST_EXTRA;
					pemp_pkg::EVK_REL: begin
						cmd.load_rel = 1'b1;
						state_nxt    = pemp_pkg::ST_STEP;
					end
					pemp_pkg::EVK_ABS: state_nxt = pemp_pkg::ST_MUL;
					default: state_nxt = pemp_pkg::ST_IDLE;
				endcase
			end
			pemp_pkg::ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = sts.range_empty ? pemp_pkg::ST_SCALE : pemp_pkg::ST_DIV_GO;
			end
			pemp_pkg::ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_nxt     = pemp_pkg::ST_DIV_WAIT;
			end
			pemp_pkg::ST_DIV_WAIT: begin
				if (sts.div_done) begin
					state_nxt = pemp_pkg::ST_SCALE;
				end
			end
			pemp_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				state_nxt = pemp_pkg::ST_STORE;
			end
			pemp_pkg::ST_STORE: begin
				// first sample on an axis only sets the baseline
				cmd.store      = 1'b1;
				cmd.load_delta = sts.axis_seen;
				state_nxt      = sts.axis_seen ? pemp_pkg::ST_STEP : pemp_pkg::ST_IDLE;
			end
			pemp_pkg::ST_STEP: begin
				if (sts.out_free) begin
					cmd.emit_step = 1'b1;
					if (sts.step_last) begin
						state_nxt = pemp_pkg::ST_IDLE;
					end
				end
			end
			pemp_pkg::ST_EXTRA: begin
				if (sts.out_free) begin
					cmd.emit_extra = 1'b1;
					state_nxt      = pemp_pkg::ST_IDLE;
				end
			end
			default: state_nxt = pemp_pkg::ST_IDLE;
		endcase
	end

endmodule

FILE: hdl/pemp_dp.sv
// ----------------------------------------------------------------------------
// pemp_dp: datapath of the pointer event converter
// Configuration registers, button and axis state, scaling multiplier and
// divider, motion stepper and the result register.
// ----------------------------------------------------------------------------
module pemp_dp #(
	parameter int MAX_STEPS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pemp_pkg::CFG_AW-1:0]   cfg_index,
	input  logic [pemp_pkg::CFG_DW-1:0]   cfg_wdata,
	input  logic [15:0]                   ev_type,
	input  logic [15:0]                   ev_code,
	input  logic signed [31:0]            ev_value,
	input  pemp_pkg::cmd_t                cmd,
	output pemp_pkg::sts_t                sts,
	input  logic                          res_ready,
	output logic                          res_valid,
	output logic                          res_kind,
	output logic [7:0]                    res_header,
	output logic signed [7:0]             res_dx,
	output logic signed [7:0]             res_dy,
	output logic [7:0]                    res_extra,
	output logic                          res_last
);

	localparam int VW = pemp_pkg::VAL_W;
	localparam int DF = pemp_pkg::DIFF_W;
	localparam int PW = pemp_pkg::PROD_W;
	localparam int DW = $clog2(MAX_STEPS * 128) + 1;
	localparam int CW = $clog2(MAX_STEPS + 1);

	localparam logic signed [DF-1:0] LIM_LO = DF'(-(MAX_STEPS * 128));
	localparam logic signed [DF-1:0] LIM_HI = DF'(MAX_STEPS * 127);
	localparam logic signed [DW-1:0] S_HI   = DW'(pemp_pkg::STEP_HI);
	localparam logic signed [DW-1:0] S_LO   = DW'(pemp_pkg::STEP_LO);
	localparam logic [PW-1:0] Q_POS_LIM = PW'(33'h0_7FFF_FFFF);
	localparam logic [PW-1:0] Q_NEG_LIM = PW'(33'h0_8000_0000);

	// Configuration
	logic signed [VW-1:0]          x_min_q, x_max_q, y_min_q, y_max_q;
	logic [pemp_pkg::SCR_W-1:0]    scr_x_q, scr_y_q;

	// Latched event
	logic [15:0]          ev_type_q;
	logic [15:0]          ev_code_q;
	logic signed [VW-1:0] ev_value_q;

	// Persistent state
	logic [1:0]           button_q;
	logic                 x_seen_q, y_seen_q;
	logic signed [VW-1:0] last_x_q, last_y_q;

	// Scaling
	logic signed [DF-1:0] diff_q;
	logic [VW-1:0]        span_q;
	logic                 empty_q;
	logic                 neg_q;
	logic [PW-1:0]        prod_q;
	logic [PW-1:0]        quot;
	logic                 div_done;
	logic signed [VW-1:0] scaled_q;

	// Stepper
	logic signed [DW-1:0] dx_q, dy_q;
	logic [CW-1:0]        cnt_q;

	// Result register
	logic                 out_valid_q;
	logic                 out_kind_q;
	logic [7:0]           out_hdr_q;
	logic signed [7:0]    out_dx_q, out_dy_q;
	logic [7:0]           out_extra_q;
	logic                 out_last_q;

	// Combinational
	pemp_pkg::evk_t       kind;
	logic                 axis_y;
	logic signed [VW-1:0] sel_lo, sel_hi, sel_last;
	logic [pemp_pkg::SCR_W-1:0] sel_scr;
	logic signed [DF-1:0] span_full;
	logic [DF-1:0]        mag;
	logic signed [VW-1:0] scaled_nxt;
	logic signed [DF-1:0] delta;
	logic signed [DF-1:0] load_src;
	logic signed [DW-1:0] load_clamp;
	logic signed [7:0]    sx, sy;
	logic signed [DW-1:0] dx_nxt, dy_nxt;
	logic                 step_last;
	logic                 out_free;

	// Write configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= '0;
			x_max_q <= '0;
			y_min_q <= '0;
			y_max_q <= '0;
			scr_x_q <= pemp_pkg::SCR_X_RESET;
			scr_y_q <= pemp_pkg::SCR_Y_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pemp_pkg::CFG_X_MIN: x_min_q <= cfg_wdata;
				pemp_pkg::CFG_X_MAX: x_max_q <= cfg_wdata;
				pemp_pkg::CFG_Y_MIN: y_min_q <= cfg_wdata;
				pemp_pkg::CFG_Y_MAX: y_max_q <= cfg_wdata;
				pemp_pkg::CFG_SCR_X: scr_x_q <= cfg_wdata[pemp_pkg::SCR_W-1:0];
				pemp_pkg::CFG_SCR_Y: scr_y_q <= cfg_wdata[pemp_pkg::SCR_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold the accepted event
	always_ff @(posedge clk) begin
		if (cmd.load_event) begin
			ev_type_q  <= ev_type;
			ev_code_q  <= ev_code;
			ev_value_q <= ev_value;
		end
	end

	// Classify the held event
	always_comb begin
		kind = pemp_pkg::EVK_NONE;
		case (ev_type_q)
			pemp_pkg::EV_TYPE_KEY: begin
				if (ev_code_q == pemp_pkg::EV_BTN_LEFT || ev_code_q == pemp_pkg::EV_BTN_RGHT) begin
					kind = pemp_pkg::EVK_BUTTON;
				end else if (ev_code_q == pemp_pkg::EV_BTN_MID) begin
					kind = pemp_pkg::EVK_MIDDLE;
				end
			end
			pemp_pkg::EV_TYPE_REL: begin
				if (ev_code_q == pemp_pkg::EV_AXIS_X || ev_code_q == pemp_pkg::EV_AXIS_Y) begin
					kind = pemp_pkg::EVK_REL;
				end
			end
			pemp_pkg::EV_TYPE_ABS: begin
				if (ev_code_q == pemp_pkg::EV_AXIS_X || ev_code_q == pemp_pkg::EV_AXIS_Y) begin
					kind = pemp_pkg::EVK_ABS;
				end
			end
			default: kind = pemp_pkg::EVK_NONE;
		endcase
	end

	// Axis selection: axis codes differ only in bit 0
	assign axis_y   = ev_code_q[0];
	assign sel_lo   = axis_y ? y_min_q : x_min_q;
	assign sel_hi   = axis_y ? y_max_q : x_max_q;
	assign sel_scr  = axis_y ? scr_y_q : scr_x_q;
	assign sel_last = axis_y ? last_y_q : last_x_q;

	// Button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_q <= '0;
		end else if (cmd.button_update) begin
			if (ev_value_q != '0) begin
				button_q <= button_q | ((ev_code_q == pemp_pkg::EV_BTN_LEFT) ?
					pemp_pkg::BIT_LEFT : pemp_pkg::BIT_RIGHT);
			end else begin
				button_q <= button_q & ~((ev_code_q == pemp_pkg::EV_BTN_LEFT) ?
					pemp_pkg::BIT_LEFT : pemp_pkg::BIT_RIGHT);
			end
		end
	end

	// Offset and span of the axis range
	assign span_full = {sel_hi[VW-1], sel_hi} - {sel_lo[VW-1], sel_lo};
	assign mag       = diff_q[DF-1] ? DF'(-diff_q) : diff_q;

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			diff_q  <= {ev_value_q[VW-1], ev_value_q} - {sel_lo[VW-1], sel_lo};
			span_q  <= span_full[VW-1:0];
			empty_q <= (sel_hi <= sel_lo);
		end
		if (cmd.mul) begin
			prod_q <= PW'(mag) * PW'(sel_scr);
			neg_q  <= diff_q[DF-1];
		end
		if (cmd.scale) begin
			scaled_q <= scaled_nxt;
		end
	end

	pemp_div #(
		.NUM_W (PW),
		.DEN_W (VW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (prod_q),
		.den    (span_q),
		.quot   (quot),
		.done   (div_done)
	);

	// Apply the sign and saturate to the signed 32-bit range; an empty range gives zero
	always_comb begin
		if (empty_q) begin
			scaled_nxt = '0;
		end else if (!neg_q) begin
			scaled_nxt = (quot > Q_POS_LIM) ? Q_POS_LIM[VW-1:0] : quot[VW-1:0];
		end else begin
			scaled_nxt = (quot > Q_NEG_LIM) ? Q_NEG_LIM[VW-1:0] : VW'(-quot[VW-1:0]);
		end
	end

	// Baseline per axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_seen_q <= 1'b0;
			y_seen_q <= 1'b0;
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (cmd.store) begin
			if (axis_y) begin
				y_seen_q <= 1'b1;
				last_y_q <= scaled_q;
			end else begin
				x_seen_q <= 1'b1;
				last_x_q <= scaled_q;
			end
		end
	end

	// Motion to send, saturated to what MAX_STEPS packets carry
	assign delta    = {scaled_q[VW-1], scaled_q} - {sel_last[VW-1], sel_last};
	assign load_src = cmd.load_rel ? {ev_value_q[VW-1], ev_value_q} : delta;
	assign load_clamp = (load_src > LIM_HI) ? LIM_HI[DW-1:0] :
		(load_src < LIM_LO) ? LIM_LO[DW-1:0] : load_src[DW-1:0];

	// Cut one packet step off the remaining motion
	assign sx = (dx_q > S_HI) ? pemp_pkg::STEP_HI : (dx_q < S_LO) ? pemp_pkg::STEP_LO : dx_q[7:0];
	assign sy = (dy_q > S_HI) ? pemp_pkg::STEP_HI : (dy_q < S_LO) ? pemp_pkg::STEP_LO : dy_q[7:0];
	assign dx_nxt = dx_q - {{(DW-8){sx[7]}}, sx};
	assign dy_nxt = dy_q - {{(DW-8){sy[7]}}, sy};
	assign step_last = ((dx_nxt == '0) && (dy_nxt == '0)) || (cnt_q == CW'(MAX_STEPS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load_zero || cmd.load_rel || cmd.load_delta) begin
			dx_q <= (!cmd.load_zero && !axis_y) ? load_clamp : '0;
			dy_q <= (!cmd.load_zero && axis_y) ? load_clamp : '0;
		end else if (cmd.emit_step) begin
			dx_q <= dx_nxt;
			dy_q <= dy_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_zero || cmd.load_rel || cmd.load_delta) begin
			cnt_q <= '0;
		end else if (cmd.emit_step) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// Result register: free when empty or its beat is taken
	assign out_free = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_step || cmd.emit_extra) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_step) begin
			out_kind_q  <= pemp_pkg::KIND_PACKET;
			out_hdr_q   <= pemp_pkg::HDR_BASE | {6'b0, button_q};
			out_dx_q    <= sx;
			out_dy_q    <= sy;
			out_extra_q <= '0;
			out_last_q  <= step_last;
		end else if (cmd.emit_extra) begin
			out_kind_q  <= pemp_pkg::KIND_EXTRA;
			out_hdr_q   <= '0;
			out_dx_q    <= '0;
			out_dy_q    <= '0;
			out_extra_q <= (ev_value_q != '0) ? pemp_pkg::EXTRA_PRESS : pemp_pkg::EXTRA_RELEASE;
			out_last_q  <= 1'b1;
		end
	end

	assign res_valid  = out_valid_q;
	assign res_kind   = out_kind_q;
	assign res_header = out_hdr_q;
	assign res_dx     = out_dx_q;
	assign res_dy     = out_dy_q;
	assign res_extra  = out_extra_q;
	assign res_last   = out_last_q;

	// Status to the controller
	always_comb begin
		sts             = '0;
		sts.kind        = kind;
		sts.range_empty = empty_q;
		sts.axis_seen   = axis_y ? y_seen_q : x_seen_q;
		sts.out_free    = out_free;
		sts.div_done    = div_done;
		sts.step_last   = step_last;
	end

endmodule

FILE: hdl/pointer_event_to_mouse_packets.sv
// A button or relative event goes from decode straight to packet emission; an
// absolute event first passes the multiplier and the 48-step divider (skipped when
// the axis range is empty). Further packets of one event follow one per cycle
// while the sink takes them. One event is handled at a time; the next is accepted
// the cycle after the last result is loaded into the output register.
// Reset clears button, axis and handshake state and loads configuration defaults.
// ----------------------------------------------------------------------------
// pointer_event_to_mouse_packets: pointer events to relative mouse packets
// Controller and datapath joined by command and status groups.
// ----------------------------------------------------------------------------
module pointer_event_to_mouse_packets #(
	parameter int MAX_STEPS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pemp_pkg::CFG_AW-1:0] cfg_index,
	input  logic [pemp_pkg::CFG_DW-1:0] cfg_wdata,
	pemp_event_if.sink                  pointer,
	pemp_result_if.source               packet
);

	pemp_pkg::cmd_t cmd;
	pemp_pkg::sts_t sts;

	pemp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_valid (pointer.valid),
		.ev_ready (pointer.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pemp_dp #(
		.MAX_STEPS (MAX_STEPS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.ev_type    (pointer.event_type),
		.ev_code    (pointer.event_code),
		.ev_value   (pointer.event_value),
		.cmd        (cmd),
		.sts        (sts),
		.res_ready  (packet.ready),
		.res_valid  (packet.valid),
		.res_kind   (packet.result_kind),
		.res_header (packet.packet_header),
		.res_dx     (packet.step_dx),
		.res_dy     (packet.step_dy),
		.res_extra  (packet.extra_button_byte),
		.res_last   (packet.last_of_run)
	);

endmodule

FILE: tb/sv/pointer_event_to_mouse_packets_tb.sv
// ----------------------------------------------------------------------------
// pointer_event_to_mouse_packets_tb: self-checking bench of the pointer event
// to mouse packet converter
// Drives pointer events through the event channel and holds its own copy of
// the button, axis and configuration state. From these it works out the
// packets each event must cause. Every beat on the result channel is checked
// against the oldest outstanding packet. The run starts with directed events
// and then goes through random traffic under several configurations and
// handshake idling patterns.
// ----------------------------------------------------------------------------
module pointer_event_to_mouse_packets_tb;
	import pemp_pkg::*;

	localparam int     MAX_STEPS        = 64;
	localparam longint MOTION_LO        = -MAX_STEPS * 128;
	localparam longint MOTION_HI        = MAX_STEPS * 127;
	localparam longint INT32_LO         = -64'sd2147483648;
	localparam longint INT32_HI         = 64'sd2147483647;
	localparam int     SETTLE_CYCLES    = 80;
	localparam int     RANDOM_PER_PHASE = 62;
	localparam longint CYCLE_LIMIT      = 1000000;

	typedef struct {
		logic              kind;
		logic [7:0]        header;
		logic signed [7:0] dx;
		logic signed [7:0] dy;
		logic [7:0]        extra;
		logic              last;
	} mouse_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_AW-1:0]   cfg_index;
	logic [CFG_DW-1:0]   cfg_wdata;

	pemp_event_if  pointer_ch ();
	pemp_result_if packet_ch ();

	pointer_event_to_mouse_packets #(
		.MAX_STEPS(MAX_STEPS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pointer  (pointer_ch),
		.packet   (packet_ch)
	);

	// Packets still owed by the block, oldest first
	mouse_result_t pending_packets[$];
	int            mismatches     = 0;
	int            send_gap_pct   = 0;
	int            sink_stall_pct = 0;
	longint        cycle_count    = 0;

	// Shadow of the converter state and its registers
	logic [1:0] held_buttons = 2'b00;
	logic       x_has_base   = 1'b0;
	logic       y_has_base   = 1'b0;
	longint     base_x       = 0;
	longint     base_y       = 0;
	longint     axis_x_lo    = 0;
	longint     axis_x_hi    = 0;
	longint     axis_y_lo    = 0;
	longint     axis_y_hi    = 0;
	longint     screen_x     = SCR_X_RESET;
	longint     screen_y     = SCR_Y_RESET;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Packet prediction
	// ------------------------------------------------------------------------
	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Cut a motion into steps, one packet per step
	function automatic void queue_motion(longint dx, longint dy);
		longint        sx;
		longint        sy;
		int            n;
		mouse_result_t r;
		dx = clamp(dx, MOTION_LO, MOTION_HI);
		dy = clamp(dy, MOTION_LO, MOTION_HI);
		n  = 0;
		do begin
			sx = clamp(dx, -128, 127);
			sy = clamp(dy, -128, 127);
			dx -= sx;
			dy -= sy;
			n++;
			r.kind   = KIND_PACKET;
			r.header = HDR_BASE | {6'b0, held_buttons};
			r.dx     = sx[7:0];
			r.dy     = sy[7:0];
			r.extra  = 8'h00;
			r.last   = !((dx != 0 || dy != 0) && n < MAX_STEPS);
			pending_packets.push_back(r);
		end while (!r.last);
	endfunction

	function automatic longint scale_position(longint pos, longint lo, longint hi,
			longint scr);
		longint q;
		if (hi <= lo)
			return 0;
		q = ((pos - lo) * scr) / (hi - lo);
		return clamp(q, INT32_LO, INT32_HI);
	endfunction

	function automatic void predict_packets(logic [15:0] etype, logic [15:0] ecode,
			logic signed [31:0] evalue);
		logic [1:0]    btn_mask;
		longint        pos;
		mouse_result_t r;
		case (etype)
			EV_TYPE_KEY: begin
				if (ecode == EV_BTN_LEFT || ecode == EV_BTN_RGHT) begin
					btn_mask     = (ecode == EV_BTN_LEFT) ? BIT_LEFT : BIT_RIGHT;
					held_buttons = (evalue != 0) ? (held_buttons | btn_mask)
						: (held_buttons & ~btn_mask);
					queue_motion(0, 0);
				end else if (ecode == EV_BTN_MID) begin
					r.kind   = KIND_EXTRA;
					r.header = 8'h00;
					r.dx     = 8'sh00;
					r.dy     = 8'sh00;
					r.extra  = (evalue != 0) ? EXTRA_PRESS : EXTRA_RELEASE;
					r.last   = 1'b1;
					pending_packets.push_back(r);
				end
			end
			EV_TYPE_REL: begin
				if (ecode == EV_AXIS_X)
					queue_motion(evalue, 0);
				else if (ecode == EV_AXIS_Y)
					queue_motion(0, evalue);
			end
			EV_TYPE_ABS: begin
				// The first sample on an axis only sets the baseline
				if (ecode == EV_AXIS_X) begin
					pos = scale_position(evalue, axis_x_lo, axis_x_hi, screen_x);
					if (x_has_base)
						queue_motion(pos - base_x, 0);
					base_x     = pos;
					x_has_base = 1'b1;
				end else if (ecode == EV_AXIS_Y) begin
					pos = scale_position(evalue, axis_y_lo, axis_y_hi, screen_y);
					if (y_has_base)
						queue_motion(0, pos - base_y);
					base_y     = pos;
					y_has_base = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Result checking: sample at the edge, then pick the next stall
	// ------------------------------------------------------------------------
	function automatic void check_packet();
		mouse_result_t want;
		if (pending_packets.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected packet: kind %0d hdr %h dx %0d dy %0d extra %h last %0d",
					packet_ch.result_kind, packet_ch.packet_header, packet_ch.step_dx,
					packet_ch.step_dy, packet_ch.extra_button_byte, packet_ch.last_of_run);
			return;
		end
		want = pending_packets.pop_front();
		if (packet_ch.result_kind !== want.kind || packet_ch.packet_header !== want.header
				|| packet_ch.step_dx !== want.dx || packet_ch.step_dy !== want.dy
				|| packet_ch.extra_button_byte !== want.extra
				|| packet_ch.last_of_run !== want.last) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("packet mismatch at cycle %0d", cycle_count);
				$display("  expected: kind %0d hdr %h dx %0d dy %0d extra %h last %0d",
					want.kind, want.header, want.dx, want.dy, want.extra, want.last);
				$display("  actual:   kind %0d hdr %h dx %0d dy %0d extra %h last %0d",
					packet_ch.result_kind, packet_ch.packet_header, packet_ch.step_dx,
					packet_ch.step_dy, packet_ch.extra_button_byte, packet_ch.last_of_run);
			end
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && packet_ch.valid && packet_ch.ready)
			check_packet();
		packet_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Event driving and configuration
	// ------------------------------------------------------------------------
	task automatic send_event(logic [15:0] etype, logic [15:0] ecode,
			logic signed [31:0] evalue);
		// Hold the channel idle for a random stretch
		if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			pointer_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
		end
		pointer_ch.valid       <= 1'b1;
		pointer_ch.event_type  <= etype;
		pointer_ch.event_code  <= ecode;
		pointer_ch.event_value <= evalue;
		do @(posedge clk); while (!pointer_ch.ready);
		predict_packets(etype, ecode, evalue);
	endtask

	// Drop valid, wait for every owed packet, then let any silent event finish
	task automatic wait_idle();
		pointer_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_packets.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic write_config(logic signed [31:0] x_lo, logic signed [31:0] x_hi,
			logic signed [31:0] y_lo, logic signed [31:0] y_hi,
			logic [SCR_W-1:0] scr_x, logic [SCR_W-1:0] scr_y);
		wait_idle();
		put_reg(CFG_X_MIN, x_lo);
		put_reg(CFG_X_MAX, x_hi);
		put_reg(CFG_Y_MIN, y_lo);
		put_reg(CFG_Y_MAX, y_hi);
		put_reg(CFG_SCR_X, CFG_DW'(scr_x));
		put_reg(CFG_SCR_Y, CFG_DW'(scr_y));
		cfg_we    <= 1'b0;
		axis_x_lo = x_lo;
		axis_x_hi = x_hi;
		axis_y_lo = y_lo;
		axis_y_hi = y_hi;
		screen_x  = scr_x;
		screen_y  = scr_y;
	endtask

	// ------------------------------------------------------------------------
	// Random values
	// ------------------------------------------------------------------------
	function automatic logic signed [31:0] pick_delta();
		case ($urandom_range(0, 9))
			0:       return 32'sd0;
			6, 7:    return int'($urandom_range(0, 40000)) - 20000;
			8:       return $urandom;
			9:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: return int'($urandom_range(0, 600)) - 300;
		endcase
	endfunction

	// Mostly inside the axis range, now and then on its ends or anywhere
	function automatic logic signed [31:0] pick_position(longint lo, longint hi);
		logic [63:0] r64;
		longint      span;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'(lo);
			2: return 32'(hi);
			default: ;
		endcase
		if (hi <= lo)
			return $urandom;
		span = hi - lo + 1;
		r64  = {$urandom, $urandom};
		return 32'(lo + longint'(r64 % 64'(span)));
	endfunction

	function automatic logic signed [31:0] pick_press();
		return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1);
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_buttons_press();
		send_event(EV_TYPE_KEY, EV_BTN_LEFT, 32'sd1);
		send_event(EV_TYPE_KEY, EV_BTN_RGHT, 32'sh8000_0000);
	endtask

	task automatic test_middle_button();
		send_event(EV_TYPE_KEY, EV_BTN_MID, -32'sd1);
		send_event(EV_TYPE_KEY, EV_BTN_MID, 32'sd0);
	endtask

	// Step edges, multi-packet splits and saturation, with both buttons held
	task automatic test_relative_motion();
		send_event(EV_TYPE_REL, EV_AXIS_X, 32'sd0);
		send_event(EV_TYPE_REL, EV_AXIS_X, 32'sd127);
		send_event(EV_TYPE_REL, EV_AXIS_X, -32'sd128);
		send_event(EV_TYPE_REL, EV_AXIS_X, 32'sd128);
		send_event(EV_TYPE_REL, EV_AXIS_Y, -32'sd129);
		send_event(EV_TYPE_REL, EV_AXIS_X, 32'sh7fff_ffff);
		send_event(EV_TYPE_REL, EV_AXIS_Y, 32'sh8000_0000);
		send_event(EV_TYPE_REL, EV_AXIS_Y, 32'sd8128);
		send_event(EV_TYPE_REL, EV_AXIS_X, -32'sd8192);
	endtask

	task automatic test_buttons_release();
		send_event(EV_TYPE_KEY, EV_BTN_LEFT, 32'sd0);
		send_event(EV_TYPE_KEY, EV_BTN_RGHT, 32'sd0);
	endtask

	task automatic test_ignored_events();
		send_event(EV_TYPE_KEY, EV_BTN_MID + 16'd1, 32'sd1);
		send_event(EV_TYPE_REL, 16'd2, 32'sd55);
		send_event(EV_TYPE_ABS, 16'hffff, 32'sd77);
		send_event(16'h0000, EV_AXIS_X, 32'sd10);
		send_event(16'hffff, EV_BTN_LEFT, 32'sd1);
	endtask

	// Empty axis ranges after reset: baseline first, then a zero change
	task automatic test_absolute_baseline();
		send_event(EV_TYPE_ABS, EV_AXIS_X, 32'sd5);
		send_event(EV_TYPE_ABS, EV_AXIS_X, -32'sd7);
		send_event(EV_TYPE_ABS, EV_AXIS_Y, 32'sd1);
		send_event(EV_TYPE_ABS, EV_AXIS_Y, 32'sd2);
	endtask

	task automatic test_random_traffic(int gap_pct, int stall_pct,
			logic signed [31:0] x_lo, logic signed [31:0] x_hi,
			logic signed [31:0] y_lo, logic signed [31:0] y_hi,
			logic [SCR_W-1:0] scr_x, logic [SCR_W-1:0] scr_y);
		int          sent;
		int          sel;
		logic [15:0] axis;
		write_config(x_lo, x_hi, y_lo, y_hi, scr_x, scr_y);
		send_gap_pct   = gap_pct;
		sink_stall_pct = stall_pct;
		sent = 0;
		while (sent < RANDOM_PER_PHASE) begin
			sel  = $urandom_range(0, 99);
			axis = $urandom_range(0, 1) ? EV_AXIS_Y : EV_AXIS_X;
			if (sel < 16) begin
				send_event(EV_TYPE_KEY, $urandom_range(0, 1) ? EV_BTN_LEFT : EV_BTN_RGHT,
					pick_press());
				sent++;
			end else if (sel < 24) begin
				send_event(EV_TYPE_KEY, EV_BTN_MID, pick_press());
				sent++;
			end else if (sel < 50) begin
				send_event(EV_TYPE_REL, axis, pick_delta());
				sent++;
			end else if (sel < 90) begin
				send_event(EV_TYPE_ABS, axis, (axis == EV_AXIS_X)
					? pick_position(axis_x_lo, axis_x_hi)
					: pick_position(axis_y_lo, axis_y_hi));
				sent++;
			end else begin
				// Noise: arbitrary classes and codes, mostly ignored
				case ($urandom_range(0, 2))
					0: send_event(16'($urandom), 16'($urandom), $urandom);
					1: send_event(EV_TYPE_KEY, 16'($urandom), $urandom);
					default: send_event($urandom_range(0, 1) ? EV_TYPE_REL : EV_TYPE_ABS,
						16'($urandom), $urandom);
				endcase
				sent++;
			end
		end
	endtask

	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = CFG_X_MIN;
		cfg_wdata              = '0;
		pointer_ch.valid       = 1'b0;
		pointer_ch.event_type  = '0;
		pointer_ch.event_code  = '0;
		pointer_ch.event_value = '0;
		packet_ch.ready        = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_buttons_press();
		test_middle_button();
		test_relative_motion();
		test_buttons_release();
		test_ignored_events();
		test_absolute_baseline();

		test_random_traffic(0, 0, 32'sd0, 32'sd4095, 32'sd0, 32'sd4095,
			15'd1919, 15'd1079);
		test_random_traffic(49, 0, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh7fff_ffff, 15'd32767, 15'd32767);
		test_random_traffic(0, 49, 32'sd100, -32'sd1, -32'sd1, 32'sd7,
			15'd0, 15'd255);
		test_random_traffic(21, 21, -32'sd1000, 32'sd1000, 32'sd0, 32'sd1,
			15'd639, 15'd32767);

		wait_idle();
		if (mismatches == 0 && pending_packets.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/pemp_pkg.sv
hdl/pemp_event_if.sv
hdl/pemp_result_if.sv
hdl/pemp_div.sv
hdl/pemp_ctrl.sv
hdl/pemp_dp.sv
hdl/pointer_event_to_mouse_packets.sv
tb/sv/pointer_event_to_mouse_packets_tb.sv
